[hdl/sbbm_pkg.sv]
// sbbm_pkg: shared constants, register codes and helpers for the segment
// bounding box block. Depends on nothing; every other file imports it.

package sbbm_pkg;

   // default number formats
   localparam int COORD_BITS_DEF = 40;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int TRIG_BITS      = 16;
   localparam int TRIG_FRAC      = 14;

   // pipeline and queue sizing
   localparam int FRONT_STAGES = 8;
   localparam int QDEPTH       = 16;

   // accumulator and window reset magnitudes, whole units
   localparam longint BOX_EXTENT  = 100000;
   localparam longint HALF_EXTENT = 1000000;

   // register indexes on the csr port
   localparam int CSR_IDX_BITS = 3;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SYM_MODE    = 3'd0,
      CSR_SYM_X       = 3'd1,
      CSR_SYM_Y       = 3'd2,
      CSR_AUTO_WINDOW = 3'd3,
      CSR_WIN_XMIN    = 3'd4,
      CSR_WIN_XMAX    = 3'd5,
      CSR_WIN_YMIN    = 3'd6,
      CSR_WIN_YMAX    = 3'd7
   } csr_index_type;

   // symmetry mode codes
   typedef enum logic [2:0] {
      SYM_NONE     = 3'd0,
      SYM_X        = 3'd1,
      SYM_Y        = 3'd2,
      SYM_BOTH     = 3'd3,
      SYM_BOTH_ALT = 3'd4
   } sym_mode_type;

   // which axes get mirrored copies
   typedef struct packed {
      logic mirror_x;
      logic mirror_y;
   } mirror_type;

   function automatic mirror_type decode_sym(input logic [2:0] mode);
      mirror_type m;
      unique case (mode)
         SYM_X:        m = '{mirror_x: 1'b1, mirror_y: 1'b0};
         SYM_Y:        m = '{mirror_x: 1'b0, mirror_y: 1'b1};
         SYM_BOTH:     m = '{mirror_x: 1'b1, mirror_y: 1'b1};
         SYM_BOTH_ALT: m = '{mirror_x: 1'b1, mirror_y: 1'b1};
         default:      m = '{mirror_x: 1'b0, mirror_y: 1'b0};
      endcase
      return m;
   endfunction

   // whole number on the fixed point scale, clamped to a signed cbits range
   function automatic logic [63:0] scaled_const(input longint whole, input int cbits,
                                                input int fbits);
      longint mag;
      longint v;
      longint cmax;
      longint cmin;
      mag  = (whole < 0 ? -whole : whole) << fbits;
      v    = (whole < 0) ? -mag : mag;
      cmax = (cbits >= 64) ? 64'sh7FFF_FFFF_FFFF_FFFF : (longint'(1) << (cbits - 1)) - 1;
      cmin = -cmax - 1;
      if (v > cmax) v = cmax;
      if (v < cmin) v = cmin;
      return v;
   endfunction

endpackage

[hdl/sbbm_front.sv]
// sbbm_front: eight-stage front end. Forms the endpoints of each segment,
// folds in mirrored copies and reduces them to one per-item box.
// Depends on sbbm_pkg.

module sbbm_front #(
   parameter int COORD_BITS = sbbm_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [COORD_BITS-1:0]          in_cx,
   input  logic signed [COORD_BITS-1:0]          in_cy,
   input  logic [COORD_BITS-2:0]                 in_half,
   input  logic signed [sbbm_pkg::TRIG_BITS-1:0] in_cos,
   input  logic signed [sbbm_pkg::TRIG_BITS-1:0] in_sin,
   input  logic                                  in_last,
   input  sbbm_pkg::mirror_type                  mirror,
   input  logic signed [COORD_BITS-1:0]          sym_x,
   input  logic signed [COORD_BITS-1:0]          sym_y,
   output logic                                  out_valid,
   output logic signed [COORD_BITS-1:0]          out_min_x,
   output logic signed [COORD_BITS-1:0]          out_max_x,
   output logic signed [COORD_BITS-1:0]          out_min_y,
   output logic signed [COORD_BITS-1:0]          out_max_y,
   output logic [COORD_BITS-2:0]                 out_half,
   output logic                                  out_last,
   output logic [$clog2(sbbm_pkg::FRONT_STAGES+1)-1:0] stage_count
);
   import sbbm_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int H   = COORD_BITS - 1;
   localparam int PW  = COORD_BITS + TRIG_BITS;
   localparam int SCW = $clog2(FRONT_STAGES + 1);

   typedef logic signed [C-1:0] coord_type;

   localparam coord_type CMAX = {1'b0, {(C-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(C-1){1'b0}}};

   function automatic coord_type sat_wide(input logic signed [C:0] v);
      if (v[C] != v[C-1]) return v[C] ? CMIN : CMAX;
      return v[C-1:0];
   endfunction

   function automatic coord_type add_sat(input coord_type a, input coord_type b);
      logic signed [C:0] s;
      s = {a[C-1], a} + {b[C-1], b};
      return sat_wide(s);
   endfunction

   function automatic coord_type sub_sat(input coord_type a, input coord_type b);
      logic signed [C:0] s;
      s = {a[C-1], a} - {b[C-1], b};
      return sat_wide(s);
   endfunction

   // stage valids and side-band shift lines
   logic [FRONT_STAGES-1:0] v_ff;
   logic [H-1:0]            half_ff [FRONT_STAGES];
   logic                    last_ff [FRONT_STAGES];

   // stage 0: captured transfer
   coord_type                    s0_cx_ff, s0_cy_ff;
   logic signed [TRIG_BITS-1:0]  s0_cos_ff, s0_sin_ff;
   // stage 1: raw products
   coord_type                    s1_cx_ff, s1_cy_ff;
   logic signed [PW-1:0]         s1_prod_x_ff, s1_prod_y_ff;
   logic signed [PW-1:0]         prod_x_in, prod_y_in;
   // stage 2: scaled projections
   coord_type                    s2_cx_ff, s2_cy_ff, s2_px_ff, s2_py_ff;
   logic signed [PW-1:0]         shift_x, shift_y;
   coord_type                    px_in, py_in;
   // stage 3: endpoints
   coord_type                    s3_xb_ff, s3_xe_ff, s3_yb_ff, s3_ye_ff;
   // stage 4: ordered endpoints
   coord_type                    s4_xlo_ff, s4_xhi_ff, s4_ylo_ff, s4_yhi_ff;
   // stage 5: distance past the symmetry line
   coord_type                    s5_xlo_ff, s5_xhi_ff, s5_ylo_ff, s5_yhi_ff;
   coord_type                    s5_dxl_ff, s5_dxh_ff, s5_dyl_ff, s5_dyh_ff;
   // stage 6: mirrored extremes
   coord_type                    s6_xlo_ff, s6_xhi_ff, s6_ylo_ff, s6_yhi_ff;
   coord_type                    s6_mxl_ff, s6_mxh_ff, s6_myl_ff, s6_myh_ff;
   // stage 7: per-item box
   coord_type                    s7_min_x_ff, s7_max_x_ff, s7_min_y_ff, s7_max_y_ff;
   coord_type                    min_x_in, max_x_in, min_y_in, max_y_in;

   // products, projections and the final fold
   always_comb begin
      prod_x_in = $signed({1'b0, half_ff[0]}) * s0_cos_ff;
      prod_y_in = $signed({1'b0, half_ff[0]}) * s0_sin_ff;
      shift_x   = s1_prod_x_ff >>> TRIG_FRAC;
      shift_y   = s1_prod_y_ff >>> TRIG_FRAC;
      px_in     = sat_wide(shift_x[C:0]);
      py_in     = sat_wide(shift_y[C:0]);
      // mirroring is non-increasing, so the mirrored max becomes the new min
      min_x_in  = (mirror.mirror_x && (s6_mxl_ff < s6_xlo_ff)) ? s6_mxl_ff : s6_xlo_ff;
      max_x_in  = (mirror.mirror_x && (s6_mxh_ff > s6_xhi_ff)) ? s6_mxh_ff : s6_xhi_ff;
      min_y_in  = (mirror.mirror_y && (s6_myl_ff < s6_ylo_ff)) ? s6_myl_ff : s6_ylo_ff;
      max_y_in  = (mirror.mirror_y && (s6_myh_ff > s6_yhi_ff)) ? s6_myh_ff : s6_yhi_ff;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   // payload stages, no reset
   always_ff @(posedge clock) begin
      half_ff[0] <= in_half;
      last_ff[0] <= in_last;
      for (int i = 1; i < FRONT_STAGES; i++) begin
         half_ff[i] <= half_ff[i-1];
         last_ff[i] <= last_ff[i-1];
      end

      s0_cx_ff     <= in_cx;
      s0_cy_ff     <= in_cy;
      s0_cos_ff    <= in_cos;
      s0_sin_ff    <= in_sin;

      s1_cx_ff     <= s0_cx_ff;
      s1_cy_ff     <= s0_cy_ff;
      s1_prod_x_ff <= prod_x_in;
      s1_prod_y_ff <= prod_y_in;

      s2_cx_ff     <= s1_cx_ff;
      s2_cy_ff     <= s1_cy_ff;
      s2_px_ff     <= px_in;
      s2_py_ff     <= py_in;

      s3_xb_ff     <= sub_sat(s2_cx_ff, s2_px_ff);
      s3_xe_ff     <= add_sat(s2_cx_ff, s2_px_ff);
      s3_yb_ff     <= sub_sat(s2_cy_ff, s2_py_ff);
      s3_ye_ff     <= add_sat(s2_cy_ff, s2_py_ff);

      s4_xlo_ff    <= (s3_xb_ff < s3_xe_ff) ? s3_xb_ff : s3_xe_ff;
      s4_xhi_ff    <= (s3_xb_ff < s3_xe_ff) ? s3_xe_ff : s3_xb_ff;
      s4_ylo_ff    <= (s3_yb_ff < s3_ye_ff) ? s3_yb_ff : s3_ye_ff;
      s4_yhi_ff    <= (s3_yb_ff < s3_ye_ff) ? s3_ye_ff : s3_yb_ff;

      s5_xlo_ff    <= s4_xlo_ff;
      s5_xhi_ff    <= s4_xhi_ff;
      s5_ylo_ff    <= s4_ylo_ff;
      s5_yhi_ff    <= s4_yhi_ff;
      s5_dxl_ff    <= sub_sat(sym_x, s4_xhi_ff);
      s5_dxh_ff    <= sub_sat(sym_x, s4_xlo_ff);
      s5_dyl_ff    <= sub_sat(sym_y, s4_yhi_ff);
      s5_dyh_ff    <= sub_sat(sym_y, s4_ylo_ff);

      s6_xlo_ff    <= s5_xlo_ff;
      s6_xhi_ff    <= s5_xhi_ff;
      s6_ylo_ff    <= s5_ylo_ff;
      s6_yhi_ff    <= s5_yhi_ff;
      s6_mxl_ff    <= add_sat(sym_x, s5_dxl_ff);
      s6_mxh_ff    <= add_sat(sym_x, s5_dxh_ff);
      s6_myl_ff    <= add_sat(sym_y, s5_dyl_ff);
      s6_myh_ff    <= add_sat(sym_y, s5_dyh_ff);

      s7_min_x_ff  <= min_x_in;
      s7_max_x_ff  <= max_x_in;
      s7_min_y_ff  <= min_y_in;
      s7_max_y_ff  <= max_y_in;
   end

   // hand-off to the queue
   assign out_valid   = v_ff[FRONT_STAGES-1];
   assign out_min_x   = s7_min_x_ff;
   assign out_max_x   = s7_max_x_ff;
   assign out_min_y   = s7_min_y_ff;
   assign out_max_y   = s7_max_y_ff;
   assign out_half    = half_ff[FRONT_STAGES-1];
   assign out_last    = last_ff[FRONT_STAGES-1];
   assign stage_count = SCW'($countones(v_ff));

endmodule

[hdl/sbbm_queue.sv]
// sbbm_queue: small first-in first-out register queue with fall-through read,
// placed between the front and back ends. Depends on sbbm_pkg for the
// default depth.

module sbbm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sbbm_pkg::QDEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       pop_valid,
   output logic [WIDTH-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import sbbm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

[hdl/sbbm_back.sv]
// sbbm_back: back end. Folds per-item boxes into the running box and half
// length range, and on the last segment forms the result window.
// Depends on sbbm_pkg.

module sbbm_back #(
   parameter int COORD_BITS = sbbm_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sbbm_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  logic signed [COORD_BITS-1:0] item_min_x,
   input  logic signed [COORD_BITS-1:0] item_max_x,
   input  logic signed [COORD_BITS-1:0] item_min_y,
   input  logic signed [COORD_BITS-1:0] item_max_y,
   input  logic [COORD_BITS-2:0]        item_half,
   input  logic                         item_last,
   output logic                         item_pop,
   input  logic                         auto_window,
   input  logic signed [COORD_BITS-1:0] win_xmin,
   input  logic signed [COORD_BITS-1:0] win_xmax,
   input  logic signed [COORD_BITS-1:0] win_ymin,
   input  logic signed [COORD_BITS-1:0] win_ymax,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_left_edge,
   output logic signed [COORD_BITS-1:0] rsp_right_edge,
   output logic signed [COORD_BITS-1:0] rsp_bottom_edge,
   output logic signed [COORD_BITS-1:0] rsp_top_edge,
   output logic [COORD_BITS-2:0]        rsp_longest_half_length,
   output logic [COORD_BITS-2:0]        rsp_shortest_half_length
);
   import sbbm_pkg::*;

   localparam int C = COORD_BITS;
   localparam int H = COORD_BITS - 1;

   typedef logic signed [C-1:0] coord_type;

   localparam coord_type CMAX = {1'b0, {(C-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(C-1){1'b0}}};

   localparam logic [63:0] BOX_MIN_W   = scaled_const(BOX_EXTENT, C, FRAC_BITS);
   localparam logic [63:0] BOX_MAX_W   = scaled_const(-BOX_EXTENT, C, FRAC_BITS);
   localparam logic [63:0] SHORT_W     = scaled_const(HALF_EXTENT, C, FRAC_BITS);
   localparam coord_type   BOX_MIN_INIT = BOX_MIN_W[C-1:0];
   localparam coord_type   BOX_MAX_INIT = BOX_MAX_W[C-1:0];
   localparam logic [H-1:0] SHORT_INIT  = SHORT_W[H-1:0];

   function automatic coord_type sat_wide(input logic signed [C:0] v);
      if (v[C] != v[C-1]) return v[C] ? CMIN : CMAX;
      return v[C-1:0];
   endfunction

   function automatic coord_type add_sat(input coord_type a, input coord_type b);
      logic signed [C:0] s;
      s = {a[C-1], a} + {b[C-1], b};
      return sat_wide(s);
   endfunction

   function automatic coord_type sub_sat(input coord_type a, input coord_type b);
      logic signed [C:0] s;
      s = {a[C-1], a} - {b[C-1], b};
      return sat_wide(s);
   endfunction

   logic en;

   // running accumulators
   coord_type    box_min_x_ff, box_max_x_ff, box_min_y_ff, box_max_y_ff;
   logic [H-1:0] longest_ff, shortest_ff;
   coord_type    min_x_in, max_x_in, min_y_in, max_y_in;
   logic [H-1:0] longest_in, shortest_in;

   // captured set, half spans, output register
   logic         fin_valid_ff, span_valid_ff, rsp_valid_ff;
   coord_type    fin_min_x_ff, fin_max_x_ff, fin_min_y_ff, fin_max_y_ff;
   logic [H-1:0] fin_long_ff, fin_short_ff;
   coord_type    sp_min_x_ff, sp_max_x_ff, sp_min_y_ff, sp_max_y_ff;
   coord_type    sp_hx_ff, sp_hy_ff;
   logic [H-1:0] sp_long_ff, sp_short_ff;
   logic signed [C:0] dx, dy;
   coord_type    left_ff, right_ff, bottom_ff, top_ff;
   logic [H-1:0] out_long_ff, out_short_ff;

   // the back end moves as one while the output register can take a result
   always_comb begin
      en          = !rsp_valid_ff || !rsp_stall;
      item_pop    = en && item_valid;
      min_x_in    = (item_min_x < box_min_x_ff) ? item_min_x : box_min_x_ff;
      max_x_in    = (item_max_x > box_max_x_ff) ? item_max_x : box_max_x_ff;
      min_y_in    = (item_min_y < box_min_y_ff) ? item_min_y : box_min_y_ff;
      max_y_in    = (item_max_y > box_max_y_ff) ? item_max_y : box_max_y_ff;
      longest_in  = (item_half > longest_ff)  ? item_half : longest_ff;
      shortest_in = (item_half < shortest_ff) ? item_half : shortest_ff;
      // floor of half the span, taken as the upper bits of the wide difference
      dx          = {fin_max_x_ff[C-1], fin_max_x_ff} - {fin_min_x_ff[C-1], fin_min_x_ff};
      dy          = {fin_max_y_ff[C-1], fin_max_y_ff} - {fin_min_y_ff[C-1], fin_min_y_ff};
   end

   // accumulators, returned to their start values after each set
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= BOX_MIN_INIT;
         box_max_x_ff <= BOX_MAX_INIT;
         box_min_y_ff <= BOX_MIN_INIT;
         box_max_y_ff <= BOX_MAX_INIT;
         longest_ff   <= '0;
         shortest_ff  <= SHORT_INIT;
      end else if (item_pop) begin
         if (item_last) begin
            box_min_x_ff <= BOX_MIN_INIT;
            box_max_x_ff <= BOX_MAX_INIT;
            box_min_y_ff <= BOX_MIN_INIT;
            box_max_y_ff <= BOX_MAX_INIT;
            longest_ff   <= '0;
            shortest_ff  <= SHORT_INIT;
         end else begin
            box_min_x_ff <= min_x_in;
            box_max_x_ff <= max_x_in;
            box_min_y_ff <= min_y_in;
            box_max_y_ff <= max_y_in;
            longest_ff   <= longest_in;
            shortest_ff  <= shortest_in;
         end
      end
   end

   // result stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff  <= 1'b0;
         span_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (en) begin
         fin_valid_ff  <= item_pop && item_last;
         span_valid_ff <= fin_valid_ff;
         rsp_valid_ff  <= span_valid_ff;
      end
   end

   // result stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         fin_min_x_ff <= min_x_in;
         fin_max_x_ff <= max_x_in;
         fin_min_y_ff <= min_y_in;
         fin_max_y_ff <= max_y_in;
         fin_long_ff  <= longest_in;
         fin_short_ff <= shortest_in;

         sp_min_x_ff  <= fin_min_x_ff;
         sp_max_x_ff  <= fin_max_x_ff;
         sp_min_y_ff  <= fin_min_y_ff;
         sp_max_y_ff  <= fin_max_y_ff;
         sp_hx_ff     <= dx[C:1];
         sp_hy_ff     <= dy[C:1];
         sp_long_ff   <= fin_long_ff;
         sp_short_ff  <= fin_short_ff;

         left_ff      <= auto_window ? sub_sat(sp_min_x_ff, sp_hx_ff) : win_xmin;
         right_ff     <= auto_window ? add_sat(sp_max_x_ff, sp_hx_ff) : win_xmax;
         bottom_ff    <= auto_window ? sub_sat(sp_min_y_ff, sp_hy_ff) : win_ymin;
         top_ff       <= auto_window ? add_sat(sp_max_y_ff, sp_hy_ff) : win_ymax;
         out_long_ff  <= sp_long_ff;
         out_short_ff <= sp_short_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_left_edge            = left_ff;
   assign rsp_right_edge           = right_ff;
   assign rsp_bottom_edge          = bottom_ff;
   assign rsp_top_edge             = top_ff;
   assign rsp_longest_half_length  = out_long_ff;
   assign rsp_shortest_half_length = out_short_ff;

   // a closing segment starts a result and clears the half length range
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      item_pop && item_last |=> fin_valid_ff && longest_ff == '0 && shortest_ff == SHORT_INIT)
      else $error("last segment did not start a result or clear accumulators");

   // within a set the running minimum never grows
   a_min_monotone: assert property (@(posedge clock) disable iff (reset)
      item_pop && !item_last |=> box_min_x_ff <= $past(box_min_x_ff))
      else $error("running x minimum grew inside a set");

   // a result in the span stage reaches the output register when the stage moves
   a_span_to_out: assert property (@(posedge clock) disable iff (reset)
      span_valid_ff && en |=> rsp_valid_ff)
      else $error("result lost between span stage and output register");

endmodule

[hdl/segment_bounding_box_mirror_top.sv]
// segment_bounding_box_mirror_top: top level of the segment bounding box
// block: csr registers, front end, queue and back end.
// Depends on sbbm_pkg, sbbm_front, sbbm_queue and sbbm_back.
//
//   channel | direction | flow control   | transfer when
//   req_*   | in        | valid / stall  | req_valid && !req_stall
//   rsp_*   | out       | valid / stall  | rsp_valid && !rsp_stall
//   csr_*   | in        | valid / ready  | csr_valid && csr_ready
//
// One segment per clock while req_stall is low; the back end folds one per-item box into
// the running box each clock unless a stalled result holds it. A closing segment passes
// 12 registers (8 front, queue, 3 result) on its way to rsp_valid.
// Reset is synchronous and clears valids, queue pointers, accumulators and csr registers.
// A stalled result holds the back end; the front end keeps accepting until the 16-entry
// queue, counted with items still in the front stages, is full.

module segment_bounding_box_mirror_top #(
   parameter int COORD_BITS = sbbm_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = sbbm_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // segment channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_centre_x,
   input  logic signed [COORD_BITS-1:0]          req_centre_y,
   input  logic [COORD_BITS-2:0]                 req_half_length,
   input  logic signed [sbbm_pkg::TRIG_BITS-1:0] req_cos_angle,
   input  logic signed [sbbm_pkg::TRIG_BITS-1:0] req_sin_angle,
   input  logic                                  req_last_segment,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [COORD_BITS-1:0]          rsp_left_edge,
   output logic signed [COORD_BITS-1:0]          rsp_right_edge,
   output logic signed [COORD_BITS-1:0]          rsp_bottom_edge,
   output logic signed [COORD_BITS-1:0]          rsp_top_edge,
   output logic [COORD_BITS-2:0]                 rsp_longest_half_length,
   output logic [COORD_BITS-2:0]                 rsp_shortest_half_length,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sbbm_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [COORD_BITS-1:0]                 csr_data
);
   import sbbm_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int H   = COORD_BITS - 1;
   localparam int QW  = 4 * C + H + 1;
   localparam int SCW = $clog2(FRONT_STAGES + 1);
   localparam int QCW = $clog2(QDEPTH + 1);
   localparam int TW  = $clog2(FRONT_STAGES + QDEPTH + 1);

   typedef logic signed [C-1:0] coord_type;

   localparam logic [63:0] WIN_LO_W = scaled_const(-BOX_EXTENT, C, FRAC_BITS);
   localparam logic [63:0] WIN_HI_W = scaled_const(BOX_EXTENT, C, FRAC_BITS);
   localparam coord_type   WIN_LO_INIT = WIN_LO_W[C-1:0];
   localparam coord_type   WIN_HI_INIT = WIN_HI_W[C-1:0];

   // configuration registers
   logic [2:0]  sym_mode_ff;
   coord_type   sym_x_ff, sym_y_ff;
   logic        auto_window_ff;
   coord_type   win_xmin_ff, win_xmax_ff, win_ymin_ff, win_ymax_ff;
   mirror_type  mirror;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_mode_ff    <= SYM_NONE;
         sym_x_ff       <= '0;
         sym_y_ff       <= '0;
         auto_window_ff <= 1'b1;
         win_xmin_ff    <= WIN_LO_INIT;
         win_xmax_ff    <= WIN_HI_INIT;
         win_ymin_ff    <= WIN_LO_INIT;
         win_ymax_ff    <= WIN_HI_INIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SYM_MODE:    sym_mode_ff    <= csr_data[2:0];
            CSR_SYM_X:       sym_x_ff       <= csr_data;
            CSR_SYM_Y:       sym_y_ff       <= csr_data;
            CSR_AUTO_WINDOW: auto_window_ff <= csr_data[0];
            CSR_WIN_XMIN:    win_xmin_ff    <= csr_data;
            CSR_WIN_XMAX:    win_xmax_ff    <= csr_data;
            CSR_WIN_YMIN:    win_ymin_ff    <= csr_data;
            CSR_WIN_YMAX:    win_ymax_ff    <= csr_data;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign mirror    = decode_sym(sym_mode_ff);

   // credit: items in the front stages plus queued items never exceed the queue
   logic [SCW-1:0] front_count;
   logic [QCW-1:0] q_count;
   logic [TW-1:0]  in_flight;
   logic           req_accept;

   always_comb begin
      in_flight  = TW'(front_count) + TW'(q_count);
      req_stall  = (in_flight >= TW'(QDEPTH));
      req_accept = req_valid && !req_stall;
   end

   // front end
   logic         f_valid, f_last;
   coord_type    f_min_x, f_max_x, f_min_y, f_max_y;
   logic [H-1:0] f_half;

   sbbm_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_accept),
      .in_cx       (req_centre_x),
      .in_cy       (req_centre_y),
      .in_half     (req_half_length),
      .in_cos      (req_cos_angle),
      .in_sin      (req_sin_angle),
      .in_last     (req_last_segment),
      .mirror      (mirror),
      .sym_x       (sym_x_ff),
      .sym_y       (sym_y_ff),
      .out_valid   (f_valid),
      .out_min_x   (f_min_x),
      .out_max_x   (f_max_x),
      .out_min_y   (f_min_y),
      .out_max_y   (f_max_y),
      .out_half    (f_half),
      .out_last    (f_last),
      .stage_count (front_count)
   );

   // queue between the two ends
   logic [QW-1:0] q_push_data, q_pop_data;
   logic          q_pop, q_pop_valid;

   assign q_push_data = {f_min_x, f_max_x, f_min_y, f_max_y, f_half, f_last};

   sbbm_queue #(
      .WIDTH (QW),
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_valid (q_pop_valid),
      .pop_data  (q_pop_data),
      .count     (q_count)
   );

   // back end
   sbbm_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock                    (clock),
      .reset                    (reset),
      .item_valid               (q_pop_valid),
      .item_min_x               (q_pop_data[QW-1 -: C]),
      .item_max_x               (q_pop_data[QW-1-C -: C]),
      .item_min_y               (q_pop_data[QW-1-2*C -: C]),
      .item_max_y               (q_pop_data[QW-1-3*C -: C]),
      .item_half                (q_pop_data[H:1]),
      .item_last                (q_pop_data[0]),
      .item_pop                 (q_pop),
      .auto_window              (auto_window_ff),
      .win_xmin                 (win_xmin_ff),
      .win_xmax                 (win_xmax_ff),
      .win_ymin                 (win_ymin_ff),
      .win_ymax                 (win_ymax_ff),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_left_edge            (rsp_left_edge),
      .rsp_right_edge           (rsp_right_edge),
      .rsp_bottom_edge          (rsp_bottom_edge),
      .rsp_top_edge             (rsp_top_edge),
      .rsp_longest_half_length  (rsp_longest_half_length),
      .rsp_shortest_half_length (rsp_shortest_half_length)
   );

endmodule

[tb/tb_segment_bounding_box_mirror_top.sv]
// tb_segment_bounding_box_mirror_top: self-checking bench for the segment bounding box block,
// with a queue-fed segment driver, a result monitor and a fixed point window predictor.
// Depends on sbbm_pkg and segment_bounding_box_mirror_top.

module tb_segment_bounding_box_mirror_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sbbm_pkg::*;

   localparam int     COORD_W      = COORD_BITS_DEF;
   localparam int     FRAC_W       = FRAC_BITS_DEF;
   localparam longint CMAX         = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint CMIN         = -CMAX - 1;
   localparam longint BOX_RESET    = BOX_EXTENT <<< FRAC_W;
   localparam longint SHORT_RESET  = HALF_EXTENT <<< FRAC_W;
   localparam int     DRAIN_CYCLES = 24;
   localparam int     CYCLE_LIMIT  = 400000;
   localparam int     PHASES       = 12;
   localparam int     PHASE_ITEMS  = 135;

   // one segment transfer
   typedef struct {
      logic signed [COORD_W-1:0]   cx;
      logic signed [COORD_W-1:0]   cy;
      logic [COORD_W-2:0]          half;
      logic signed [TRIG_BITS-1:0] ct;
      logic signed [TRIG_BITS-1:0] st;
      logic                        closes_set;
   } segment_type;

   // one window result
   typedef struct {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] top;
      logic [COORD_W-2:0] longest;
      logic [COORD_W-2:0] shortest;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [COORD_W-1:0]   req_centre_x = '0;
   logic signed [COORD_W-1:0]   req_centre_y = '0;
   logic [COORD_W-2:0]          req_half_length = '0;
   logic signed [TRIG_BITS-1:0] req_cos_angle = '0;
   logic signed [TRIG_BITS-1:0] req_sin_angle = '0;
   logic                        req_last_segment = 1'b0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [COORD_W-1:0]   rsp_left_edge;
   logic signed [COORD_W-1:0]   rsp_right_edge;
   logic signed [COORD_W-1:0]   rsp_bottom_edge;
   logic signed [COORD_W-1:0]   rsp_top_edge;
   logic [COORD_W-2:0]          rsp_longest_half_length;
   logic [COORD_W-2:0]          rsp_shortest_half_length;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [COORD_W-1:0]          csr_data = '0;

   segment_type       seg_pending[$];
   window_result_type window_expect[$];
   int                mismatch_count = 0;
   int                cycle_count = 0;

   // predictor configuration copy
   logic [2:0] cfg_mode = SYM_NONE;
   longint     cfg_sym_x = 0;
   longint     cfg_sym_y = 0;
   bit         cfg_auto = 1'b1;
   longint     cfg_win_left = -BOX_RESET;
   longint     cfg_win_right = BOX_RESET;
   longint     cfg_win_bottom = -BOX_RESET;
   longint     cfg_win_top = BOX_RESET;

   // predictor accumulators
   longint acc_min_x, acc_max_x, acc_min_y, acc_max_y;
   longint acc_longest, acc_shortest;

   segment_bounding_box_mirror_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_centre_x             (req_centre_x),
      .req_centre_y             (req_centre_y),
      .req_half_length          (req_half_length),
      .req_cos_angle            (req_cos_angle),
      .req_sin_angle            (req_sin_angle),
      .req_last_segment         (req_last_segment),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_left_edge            (rsp_left_edge),
      .rsp_right_edge           (rsp_right_edge),
      .rsp_bottom_edge          (rsp_bottom_edge),
      .rsp_top_edge             (rsp_top_edge),
      .rsp_longest_half_length  (rsp_longest_half_length),
      .rsp_shortest_half_length (rsp_shortest_half_length),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_coord(input longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
   endfunction

   // point reflected about a symmetry line, each step saturated
   function automatic longint reflect(input longint line_pos, input longint v);
      return clamp_coord(line_pos + clamp_coord(line_pos - v));
   endfunction

   task automatic clear_box();
      acc_min_x    = BOX_RESET;
      acc_max_x    = -BOX_RESET;
      acc_min_y    = BOX_RESET;
      acc_max_y    = -BOX_RESET;
      acc_longest  = 0;
      acc_shortest = SHORT_RESET;
   endtask

   task automatic widen_x(input longint v);
      if (v < acc_min_x) acc_min_x = v;
      if (v > acc_max_x) acc_max_x = v;
   endtask

   task automatic widen_y(input longint v);
      if (v < acc_min_y) acc_min_y = v;
      if (v > acc_max_y) acc_max_y = v;
   endtask

   // fold one accepted segment into the box, queue a window when it closes the set
   task automatic fold_segment(input longint cx, input longint cy, input longint half,
                               input longint ct, input longint st, input bit closes_set);
      longint            dx, dy, x0, x1, y0, y1, hx, hy;
      bit                flip_x, flip_y;
      window_result_type w;
      // products are exact in 64 bits, arithmetic shift floors
      dx = clamp_coord((half * ct) >>> TRIG_FRAC);
      dy = clamp_coord((half * st) >>> TRIG_FRAC);
      x0 = clamp_coord(cx - dx);
      x1 = clamp_coord(cx + dx);
      y0 = clamp_coord(cy - dy);
      y1 = clamp_coord(cy + dy);
      case (cfg_mode)
         SYM_X: begin
            flip_x = 1'b1;
            flip_y = 1'b0;
         end
         SYM_Y: begin
            flip_x = 1'b0;
            flip_y = 1'b1;
         end
         SYM_BOTH, SYM_BOTH_ALT: begin
            flip_x = 1'b1;
            flip_y = 1'b1;
         end
         default: begin
            flip_x = 1'b0;
            flip_y = 1'b0;
         end
      endcase
      if (half > acc_longest) acc_longest = half;
      if (half < acc_shortest) acc_shortest = half;
      widen_x(x0);
      widen_x(x1);
      widen_y(y0);
      widen_y(y1);
      if (flip_x) begin
         widen_x(reflect(cfg_sym_x, x0));
         widen_x(reflect(cfg_sym_x, x1));
      end
      if (flip_y) begin
         widen_y(reflect(cfg_sym_y, y0));
         widen_y(reflect(cfg_sym_y, y1));
      end
      if (closes_set) begin
         if (cfg_auto) begin
            hx       = (acc_max_x - acc_min_x) >>> 1;
            hy       = (acc_max_y - acc_min_y) >>> 1;
            w.left   = COORD_W'(clamp_coord(acc_min_x - hx));
            w.right  = COORD_W'(clamp_coord(acc_max_x + hx));
            w.bottom = COORD_W'(clamp_coord(acc_min_y - hy));
            w.top    = COORD_W'(clamp_coord(acc_max_y + hy));
         end else begin
            w.left   = cfg_win_left[COORD_W-1:0];
            w.right  = cfg_win_right[COORD_W-1:0];
            w.bottom = cfg_win_bottom[COORD_W-1:0];
            w.top    = cfg_win_top[COORD_W-1:0];
         end
         w.longest  = acc_longest[COORD_W-2:0];
         w.shortest = acc_shortest[COORD_W-2:0];
         window_expect.push_back(w);
         clear_box();
      end
   endtask

   // ------------------------------------------------------------ segment driver

   bit req_fire = 1'b0;
   int send_gap = 0;
   bit send_burst = 1'b0;

   // transfer bookkeeping at the rising edge
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire)
         fold_segment(longint'(req_centre_x), longint'(req_centre_y),
                      longint'(req_half_length), longint'(req_cos_angle),
                      longint'(req_sin_angle), req_last_segment);
   end

   // present the next segment at the falling edge, holding a stalled one
   always @(negedge clock) begin
      segment_type seg;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap   = send_gap - 1;
            req_valid <= 1'b0;
         end else if (seg_pending.size() != 0) begin
            seg = seg_pending.pop_front();
            req_valid        <= 1'b1;
            req_centre_x     <= seg.cx;
            req_centre_y     <= seg.cy;
            req_half_length  <= seg.half;
            req_cos_angle    <= seg.ct;
            req_sin_angle    <= seg.st;
            req_last_segment <= seg.closes_set;
            send_gap = send_burst ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------ result monitor

   int hold_cycles = 0;
   bit hold_burst = 1'b0;

   // receiver back pressure
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall  <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                       input logic [COORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      window_result_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (window_expect.size() == 0) begin
            $error("result transfer with no window expected");
            mismatch_count++;
         end else begin
            w = window_expect.pop_front();
            check_field("left_edge", w.left, rsp_left_edge);
            check_field("right_edge", w.right, rsp_right_edge);
            check_field("bottom_edge", w.bottom, rsp_bottom_edge);
            check_field("top_edge", w.top, rsp_top_edge);
            check_field("longest_half_length", {1'b0, w.longest},
                        {1'b0, rsp_longest_half_length});
            check_field("shortest_half_length", {1'b0, w.shortest},
                        {1'b0, rsp_shortest_half_length});
         end
         hold_cycles = hold_burst ? 0 : $urandom_range(0, 8);
         if ($urandom_range(0, 29) == 0) hold_burst = !hold_burst;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ----------------------------------------------------------------- stimulus

   task automatic push_segment(input logic signed [COORD_W-1:0] cx,
                               input logic signed [COORD_W-1:0] cy,
                               input logic [COORD_W-2:0] half,
                               input logic signed [TRIG_BITS-1:0] ct,
                               input logic signed [TRIG_BITS-1:0] st,
                               input logic closes_set);
      segment_type seg;
      seg.cx         = cx;
      seg.cy         = cy;
      seg.half       = half;
      seg.ct         = ct;
      seg.st         = st;
      seg.closes_set = closes_set;
      seg_pending.push_back(seg);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
         0: return CMAX[COORD_W-1:0];
         1: return CMIN[COORD_W-1:0];
         2, 3: return r[COORD_W-1:0];
         default: return COORD_W'(longint'($urandom_range(0, 1 << 27)) - (longint'(1) << 26));
      endcase
   endfunction

   function automatic logic [COORD_W-2:0] rand_half();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0: return '0;
         1: return CMAX[COORD_W-2:0];
         2: return r[COORD_W-2:0];
         default: return (COORD_W-1)'($urandom_range(0, 1 << 24));
      endcase
   endfunction

   function automatic logic signed [TRIG_BITS-1:0] rand_trig();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return TRIG_BITS'($urandom());
         3: return '0;
         default: return TRIG_BITS'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic push_random_set(input int len);
      for (int i = 0; i < len; i++)
         push_segment(rand_coord(), rand_coord(), rand_half(), rand_trig(), rand_trig(),
                      i == len - 1);
   endtask

   // register write, mirrored into the predictor configuration at the transfer
   task automatic csr_write(input csr_index_type idx, input logic [COORD_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SYM_MODE:    cfg_mode = data[2:0];
         CSR_SYM_X:       cfg_sym_x = longint'($signed(data));
         CSR_SYM_Y:       cfg_sym_y = longint'($signed(data));
         CSR_AUTO_WINDOW: cfg_auto = data[0];
         CSR_WIN_XMIN:    cfg_win_left = longint'($signed(data));
         CSR_WIN_XMAX:    cfg_win_right = longint'($signed(data));
         CSR_WIN_YMIN:    cfg_win_bottom = longint'($signed(data));
         CSR_WIN_YMAX:    cfg_win_top = longint'($signed(data));
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // sender holds until every window is back and the pipeline has emptied
   task automatic wait_drained();
      while (seg_pending.size() != 0 || req_valid || window_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [63:0]        r;
      logic [COORD_W-1:0] sx, sy, wl, wr, wb, wt;
      int                 phase_items;
      int                 set_len;
      clear_box();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed sets at reset configuration
      push_segment('0, '0, '0, '0, '0, 1'b1);
      push_segment(CMAX[COORD_W-1:0], CMAX[COORD_W-1:0], CMAX[COORD_W-2:0],
                   16'sd16384, 16'sd16384, 1'b1);
      push_segment(CMIN[COORD_W-1:0], CMIN[COORD_W-1:0], CMAX[COORD_W-2:0],
                   -16'sd16384, -16'sd16384, 1'b1);
      // trig at and beyond unit magnitude
      push_segment('0, '0, CMAX[COORD_W-2:0], 16'sh7FFF, 16'sh8000, 1'b1);
      push_segment('0, '0, CMAX[COORD_W-2:0], 16'sd16384, -16'sd16384, 1'b1);
      // multi-segment set
      push_segment(40'sd1000 <<< FRAC_W, -(40'sd2000 <<< FRAC_W), 39'd5 <<< FRAC_W,
                   16'sd11585, 16'sd11585, 1'b0);
      push_segment(-(40'sd3 <<< FRAC_W), 40'sd7 <<< FRAC_W, '0, -16'sd16384, '0, 1'b0);
      push_segment('0, '0, 39'd123456, '0, 16'sd16384, 1'b1);
      // bit patterns
      push_segment(-40'sd1, -40'sd1, 39'h2A_AAAA_AAAA, 16'sh5555, 16'shAAAA, 1'b0);
      push_segment(40'sh55_5555_5555, 40'shAA_AAAA_AAAA, 39'h55_5555_5555, 16'sh0001,
                   -16'sd1, 1'b1);
      push_segment(CMAX[COORD_W-1:0], CMIN[COORD_W-1:0], 39'd1, 16'sd1, -16'sd1, 1'b1);
      push_segment(-40'sd1, 40'sd1, 39'd16383, -16'sd3, 16'sd3, 1'b1);
      wait_drained();

      // configuration phases with random sets
      for (int p = 0; p < PHASES; p++) begin
         r  = {$urandom(), $urandom()};
         sx = (p == 2 || p == 11) ? CMAX[COORD_W-1:0] : (p == 3) ? CMIN[COORD_W-1:0] :
              rand_coord();
         sy = (p == 2 || p == 11) ? CMAX[COORD_W-1:0] : (p == 3) ? CMIN[COORD_W-1:0] :
              rand_coord();
         wl = (p == 4) ? CMIN[COORD_W-1:0] : rand_coord();
         wr = (p == 4) ? CMAX[COORD_W-1:0] : rand_coord();
         wb = (p == 4) ? CMAX[COORD_W-1:0] : rand_coord();
         wt = (p == 4) ? CMIN[COORD_W-1:0] : rand_coord();
         // mode and flag carry random upper bits that must be ignored
         csr_write(CSR_SYM_MODE, {r[COORD_W-1:3], (p == 11) ? SYM_BOTH : 3'(p)});
         csr_write(CSR_SYM_X, sx);
         csr_write(CSR_SYM_Y, sy);
         csr_write(CSR_AUTO_WINDOW, {r[COORD_W-1:1], p % 3 != 1});
         csr_write(CSR_WIN_XMIN, wl);
         csr_write(CSR_WIN_XMAX, wr);
         csr_write(CSR_WIN_YMIN, wb);
         csr_write(CSR_WIN_YMAX, wt);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) :
                      $urandom_range(1, 6);
            push_random_set(set_len);
            phase_items += set_len;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && window_expect.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
hdl/sbbm_pkg.sv
hdl/sbbm_front.sv
hdl/sbbm_queue.sv
hdl/sbbm_back.sv
hdl/segment_bounding_box_mirror_top.sv
tb/tb_segment_bounding_box_mirror_top.sv
